// ===== sv/kbm_pkg.sv =====
// kbm_pkg: shared types and codes for the key binding match table
// beat payload structs, binding entry layout, status codes, sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kbm_pkg;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_ADD    = 1'b1;

    localparam logic [1:0] EV_DOWN  = 2'd0;
    localparam logic [1:0] EV_UP    = 2'd1;
    // both of these count as other events
    localparam logic [1:0] EV_OTHER = 2'd2;
    localparam logic [1:0] EV_SPARE = 2'd3;

    localparam logic [1:0] ST_LOOKUP = 2'd0;
    localparam logic [1:0] ST_ADDED  = 2'd1;
    localparam logic [1:0] ST_BOUND  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [1:0]  event_type;
        logic [31:0] key_code;
        logic [15:0] modifier;
        logic        is_repeat;
        logic [7:0]  action_in;
        logic        repeatable_in;
    } t_in_item;

    typedef struct packed {
        logic        matched;
        logic [7:0]  action_out;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [31:0] key_code;
        logic [15:0] modifier;
        logic [7:0]  action;
        logic        repeatable;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/kbm_bind_mem.sv =====
// kbm_bind_mem: binding entry store for both tables, one write and one read port
// registered read data; uses kbm_pkg::t_entry
`timescale 1ns / 1ps
`default_nettype none

module kbm_bind_mem #(
    parameter int AW = 5
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire  [AW-1:0]        i_waddr,
    input  kbm_pkg::t_entry      i_wdata,
    input  wire                  i_re,
    input  wire  [AW-1:0]        i_raddr,
    output kbm_pkg::t_entry      o_rdata
);

    kbm_pkg::t_entry r_mem [2**AW];
    kbm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/kbm_seq.sv =====
// kbm_seq: item sequencer, holds the table counts and scans the store one entry a cycle
// drives kbm_bind_mem ports; uses kbm_pkg types, codes and states
`timescale 1ns / 1ps
`default_nettype none

module kbm_seq #(
    parameter int TABLE_DEPTH = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  kbm_pkg::t_in_item    i_in_item,
    output logic                 o_mem_we,
    output logic [IW:0]          o_mem_waddr,
    output kbm_pkg::t_entry      o_mem_wdata,
    output logic                 o_mem_re,
    output logic [IW:0]          o_mem_raddr,
    input  kbm_pkg::t_entry      i_mem_rdata,
    output logic                 o_res_valid,
    output kbm_pkg::t_out_item   o_res,
    input  wire                  i_res_free
);

    kbm_pkg::t_state   r_state, n_state;
    kbm_pkg::t_in_item r_item;
    logic              r_tbl;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    logic [CW-1:0]     r_down_cnt, n_down_cnt;
    logic [CW-1:0]     r_up_cnt, n_up_cnt;
    logic [7:0]        r_hit_act;
    logic              r_hit_rep;

    logic [CW-1:0]     cur_cnt;
    logic              hit;
    logic              tbl_full;
    logic              accept;
    logic              in_tbl;
    logic              lookup_usable;

    assign cur_cnt  = r_tbl ? r_up_cnt : r_down_cnt;
    assign tbl_full = (cur_cnt == CW'(TABLE_DEPTH));
    assign hit      = r_pend && (i_mem_rdata.key_code == r_item.key_code)
                      && (i_mem_rdata.modifier == r_item.modifier);
    assign accept   = i_in_valid && o_in_ready;
    // add: anything but key-down goes to the up table; lookup: only types 0 and 1 scan
    assign in_tbl   = (i_in_item.kind == kbm_pkg::KIND_ADD) ?
                      (i_in_item.event_type != kbm_pkg::EV_DOWN) : i_in_item.event_type[0];
    assign lookup_usable = r_found && !(r_item.is_repeat && !r_hit_rep);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_found     = r_found;
        n_down_cnt  = r_down_cnt;
        n_up_cnt    = r_up_cnt;
        o_in_ready  = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_raddr = {r_tbl, r_idx[IW-1:0]};
        o_mem_we    = 1'b0;
        o_mem_waddr = {r_tbl, cur_cnt[IW-1:0]};
        o_mem_wdata = '{key_code: r_item.key_code, modifier: r_item.modifier,
                        action: r_item.action_in, repeatable: r_item.repeatable_in};
        o_res_valid = 1'b0;
        o_res       = '{matched: 1'b0, action_out: 8'd0, status: kbm_pkg::ST_LOOKUP};

        if (r_item.kind == kbm_pkg::KIND_ADD) begin
            o_res.status = r_found ? kbm_pkg::ST_BOUND :
                           (tbl_full ? kbm_pkg::ST_FULL : kbm_pkg::ST_ADDED);
        end else begin
            o_res.matched    = lookup_usable;
            o_res.action_out = lookup_usable ? r_hit_act : 8'd0;
        end

        unique case (r_state)
            kbm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    // other event types on lookup never touch the store
                    if (i_in_item.kind == kbm_pkg::KIND_LOOKUP &&
                        i_in_item.event_type[1]) begin
                        n_state = kbm_pkg::S_DONE;
                    end else begin
                        n_state = kbm_pkg::S_SCAN;
                    end
                end
            end
            kbm_pkg::S_SCAN: begin
                // read issue and compare of the previous beat overlap
                if (hit) begin
                    n_found = 1'b1;
                    n_pend  = 1'b0;
                    n_state = kbm_pkg::S_DONE;
                end else if (r_idx < cur_cnt) begin
                    o_mem_re = 1'b1;
                    n_idx    = r_idx + CW'(1);
                    n_pend   = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = kbm_pkg::S_DONE;
                end
            end
            kbm_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = kbm_pkg::S_IDLE;
                    if (r_item.kind == kbm_pkg::KIND_ADD && !r_found && !tbl_full) begin
                        o_mem_we = 1'b1;
                        if (r_tbl) begin
                            n_up_cnt = r_up_cnt + CW'(1);
                        end else begin
                            n_down_cnt = r_down_cnt + CW'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = kbm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kbm_pkg::S_IDLE;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_down_cnt <= '0;
            r_up_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_found    <= n_found;
            r_down_cnt <= n_down_cnt;
            r_up_cnt   <= n_up_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
            r_tbl  <= in_tbl;
        end
        if (r_state == kbm_pkg::S_SCAN && hit) begin
            r_hit_act <= i_mem_rdata.action;
            r_hit_rep <= i_mem_rdata.repeatable;
        end
    end

endmodule

`default_nettype wire

// ===== sv/key_binding_match_table_unit.sv =====
// key_binding_match_table_unit: top level, sequencer plus binding store plus result register
// depends on kbm_pkg, kbm_seq, kbm_bind_mem
//
//  beat   | valid        | ready        | payload
//  -------+--------------+--------------+--------------------------
//  in     | i_in_valid   | o_in_ready   | i_in_item  (kbm_pkg::t_in_item)
//  out    | o_out_valid  | i_out_ready  | o_out_item (kbm_pkg::t_out_item)
//
// one item at a time; an item is checked against the bindings in its table
// by the single read port, one entry a cycle, until a match or the table's end
// other-type lookups skip the scan; a new add with room writes its entry on the way out
// synchronous active-low reset empties both tables (counts to zero), no clearing pass
// a result waiting in the output register does not block accepting the next item;
// that item finishes its scan and holds until the register frees
`timescale 1ns / 1ps
`default_nettype none

module key_binding_match_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  kbm_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output kbm_pkg::t_out_item   o_out_item
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic               mem_we;
    logic [IW:0]        mem_waddr;
    kbm_pkg::t_entry    mem_wdata;
    logic               mem_re;
    logic [IW:0]        mem_raddr;
    kbm_pkg::t_entry    mem_rdata;
    logic               res_valid;
    kbm_pkg::t_out_item res;
    logic               res_free;

    logic               r_out_valid;
    kbm_pkg::t_out_item r_out_item;

    assign res_free = !r_out_valid || i_out_ready;

    kbm_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW),
        .CW          (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_free  (res_free)
    );

    kbm_bind_mem #(
        .AW (IW + 1)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_free) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted item occupies the sequencer for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after an accept");

    // add results never carry a match
    a_add_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != kbm_pkg::ST_LOOKUP |->
            !o_out_item.matched && o_out_item.action_out == 8'd0)
        else $error("add result carries match fields");

    // a miss reports action zero
    a_miss_zero_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.matched |-> o_out_item.action_out == 8'd0)
        else $error("nonzero action without a match");

endmodule

`default_nettype wire
